// ----- hdl/hebp_pkg.sv -----
// shared constants and types for the huffman encoder bit packer
`default_nettype none

package hebp_pkg;

   localparam int OP_W     = 2;
   localparam int SYM_W    = 8;
   localparam int CODE_W   = 32;
   localparam int LEN_W    = 6;
   localparam int BYTE_W   = 8;
   localparam int DEPTH    = 256;
   localparam int PEND_W   = 7;
   localparam int PCNT_W   = 3;
   localparam int ACC_W    = CODE_W + PEND_W;
   localparam int TOTAL_W  = 6;
   localparam int NBYTE_W  = 3;

   localparam int MAX_CODE_LEN  = 32;
   localparam int HW_CODE_LIMIT = 32;
   localparam int CODE_LIMIT    = (MAX_CODE_LEN < HW_CODE_LIMIT) ? MAX_CODE_LEN
                                                                 : HW_CODE_LIMIT;

   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
   localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

   typedef struct packed {
      logic [LEN_W-1:0]  length;
      logic [CODE_W-1:0] bits;
   } entry_type;

endpackage

`default_nettype wire

// ----- hdl/hebp_req_if.sv -----
// request channel interface: op, symbol and code word
`default_nettype none

interface hebp_req_if
   import hebp_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [SYM_W-1:0]  symbol;
   logic [CODE_W-1:0] code_bits;
   logic [LEN_W-1:0]  code_length;

   modport source (output valid, output op, output symbol, output code_bits,
                   output code_length, input ready);
   modport sink   (input valid, input op, input symbol, input code_bits,
                   input code_length, output ready);
endinterface

`default_nettype wire

// ----- hdl/hebp_rsp_if.sv -----
// response channel interface: packed byte and last flag
`default_nettype none

interface hebp_rsp_if
   import hebp_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] packed_byte;
   logic              last;

   modport source (output valid, output packed_byte, output last, input ready);
   modport sink   (input valid, input packed_byte, input last, output ready);
endinterface

`default_nettype wire

// ----- hdl/huffman_encoder_bit_packer.sv -----
// huffman encoder with code table memory and byte packer, top level
// path: first byte of an encode or flush is held in stage 1, then the output buffer
// throughput: one request per cycle while each request yields at most one byte and
//   rsp is ready; a request yielding more holds the output buffer until its last byte
//   leaves; the table memory read port (one lookup per cycle) never limits the rate
// reset: synchronous, clears the 256 entry valid flops at once, pending bits and
//   the output buffer; no clearing pass over the table memory
`default_nettype none

module huffman_encoder_bit_packer
   import hebp_pkg::*;
   (
   input  wire logic  clock,
   input  wire logic  reset,
   hebp_req_if.sink   req_chan,
   hebp_rsp_if.source rsp_chan
   );

   // ---------------------------------------------------------------
   // code table: lengths and bits in memory, valid bits in flops
   // ---------------------------------------------------------------
   entry_type            mem [DEPTH];
   entry_type            dout_ff;
   logic [DEPTH-1:0]     valid_ff;
   logic [DEPTH-1:0]     valid_in;

   logic                 req_fire;
   logic                 load_ok;
   logic [CODE_W:0]      load_mask;
   entry_type            load_entry;

   assign req_fire = req_chan.valid && req_chan.ready;
   // loads longer than the code limit leave the entry untouched
   assign load_ok  = req_fire && (req_chan.op == OP_LOAD) &&
                     (req_chan.code_length <= LEN_W'(CODE_LIMIT));
   // drop code bits above the code length
   assign load_mask = ((CODE_W+1)'(1) << req_chan.code_length) - (CODE_W+1)'(1);
   assign load_entry.length = req_chan.code_length;
   assign load_entry.bits   = req_chan.code_bits & load_mask[CODE_W-1:0];

   // write and registered read; one request per cycle, so a load always
   // lands before any later lookup of the same symbol
   always_ff @(posedge clock) begin
      if (load_ok) begin
         mem[req_chan.symbol] <= load_entry;
      end
      if (req_fire) begin
         dout_ff <= mem[req_chan.symbol];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load_ok) begin
         valid_in[req_chan.symbol] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 1: lookup result meets the bit accumulator
   // ---------------------------------------------------------------
   logic              s1_valid_ff, s1_valid_in;
   logic [OP_W-1:0]   s1_op_ff;
   logic              s1_hit_ff;

   logic [PEND_W-1:0] pend_bits_ff, pend_bits_in;
   logic [PCNT_W-1:0] pend_cnt_ff, pend_cnt_in;

   logic [ACC_W-1:0]   acc;
   logic [TOTAL_W-1:0] total;
   logic [PCNT_W-1:0]  rem;
   logic [NBYTE_W-1:0] s1_nbytes;
   logic [CODE_W-1:0]  s1_word;
   logic               buf_free;
   logic               s1_advance;

   // append the entry's code below the pending bits
   assign acc   = (ACC_W'(pend_bits_ff) << dout_ff.length) | ACC_W'(dout_ff.bits);
   assign total = TOTAL_W'(pend_cnt_ff) + dout_ff.length;
   assign rem   = total[PCNT_W-1:0];

   always_comb begin
      s1_nbytes    = '0;
      s1_word      = '0;
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      case (s1_op_ff)
         OP_ENCODE: begin
            if (s1_hit_ff) begin
               // completed bytes sit above the leftover bits
               s1_nbytes    = total[TOTAL_W-1:PCNT_W];
               s1_word      = CODE_W'(acc >> rem);
               pend_bits_in = acc[PEND_W-1:0] &
                              PEND_W'((8'd1 << rem) - 8'd1);
               pend_cnt_in  = rem;
            end
         end
         OP_FLUSH: begin
            if (pend_cnt_ff != '0) begin
               // partial byte padded with zeros at the low end
               s1_nbytes    = NBYTE_W'(1);
               s1_word      = CODE_W'(BYTE_W'({1'b0, pend_bits_ff} <<
                                      (4'd8 - 4'(pend_cnt_ff))));
               pend_bits_in = '0;
               pend_cnt_in  = '0;
            end
         end
         default: begin
            // loads and the unused op leave the accumulator alone
         end
      endcase
   end

   // ---------------------------------------------------------------
   // output buffer: up to four bytes of one request, first byte on top
   // ---------------------------------------------------------------
   logic [NBYTE_W-1:0] eb_count_ff, eb_count_in;
   logic [CODE_W-1:0]  eb_word_ff, eb_word_in;
   logic               rsp_fire;
   logic [1:0]         eb_idx;

   assign rsp_fire   = rsp_chan.valid && rsp_chan.ready;
   assign buf_free   = (eb_count_ff == '0) ||
                       ((eb_count_ff == NBYTE_W'(1)) && rsp_chan.ready);
   // requests that make no byte never wait for the buffer
   assign s1_advance = s1_valid_ff && ((s1_nbytes == '0) || buf_free);

   assign req_chan.ready = !s1_valid_ff || s1_advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      eb_count_in = eb_count_ff;
      eb_word_in  = eb_word_ff;
      if (s1_advance && (s1_nbytes != '0)) begin
         eb_count_in = s1_nbytes;
         eb_word_in  = s1_word;
      end else if (rsp_fire) begin
         eb_count_in = eb_count_ff - NBYTE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
         eb_count_ff  <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         eb_count_ff <= eb_count_in;
         if (s1_advance) begin
            pend_bits_ff <= pend_bits_in;
            pend_cnt_ff  <= pend_cnt_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff  <= req_chan.op;
         s1_hit_ff <= valid_ff[req_chan.symbol];
      end
      eb_word_ff <= eb_word_in;
   end

   // byte count - 1 picks the byte, the final one is marked last
   assign eb_idx               = 2'(eb_count_ff - NBYTE_W'(1));
   assign rsp_chan.valid       = (eb_count_ff != '0);
   assign rsp_chan.packed_byte = eb_word_ff[{eb_idx, 3'b000} +: BYTE_W];
   assign rsp_chan.last        = (eb_count_ff == NBYTE_W'(1));

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   // a stalled stage 1 keeps its lookup data (unwritten entries read as x)
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> (s1_valid_ff && (dout_ff === $past(dout_ff))))
      else $error("stage 1 lost its lookup data while stalled");

   // the buffer is only loaded when its last byte leaves or it is empty
   a_buf_free: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && (s1_nbytes != '0)) |-> buf_free)
      else $error("output buffer overwritten");

   // a flush leaves nothing pending
   a_flush_clear: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && (s1_op_ff == OP_FLUSH)) |=> (pend_cnt_ff == '0))
      else $error("pending bits left after flush");

   // reset leaves every table entry invalid
   a_reset_invalid: assert property (@(posedge clock)
      $past(reset) |-> (valid_ff == '0))
      else $error("table entry valid after reset");

endmodule

`default_nettype wire

// ----- bench/tb_huffman_encoder_bit_packer.sv -----
// self-checking testbench for the huffman encoder bit packer top level
`default_nettype none

module tb_huffman_encoder_bit_packer;
   import hebp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // op code that the block must ignore
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // one request as the sender queues it
   typedef struct {
      logic [OP_W-1:0]   op;
      logic [SYM_W-1:0]  symbol;
      logic [CODE_W-1:0] code_bits;
      logic [LEN_W-1:0]  code_length;
      bit                hold_for_drain;   // wait for all owed bytes before sending
   } huff_req_type;

   // one packed byte as the block should deliver it
   typedef struct {
      logic [BYTE_W-1:0] packed_byte;
      logic              last;
   } packed_byte_type;

   logic clock;
   logic reset;

   hebp_req_if req_if ();
   hebp_rsp_if rsp_if ();

   huffman_encoder_bit_packer uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // requests still to be sent, and bytes the block still owes us
   huff_req_type    pending_reqs[$];
   packed_byte_type owed_bytes[$];

   // private copy of the code table and the bit accumulator
   logic              code_valid [DEPTH];
   logic [LEN_W-1:0]  code_len   [DEPTH];
   logic [CODE_W-1:0] code_word  [DEPTH];
   logic [PEND_W-1:0] carry_bits;
   int                carry_cnt;

   // handshake status flags, all updated with nonblocking writes
   logic drained;       // no byte owed as of the last edge
   logic sender_idle;   // nothing left to send and nothing on the bus
   logic calm;          // window with no idling on either side

   int fail_cnt;
   int sent_cnt;
   int n_load, n_encode, n_flush, n_unused, n_bytes;

   // generator bookkeeping: symbols known to hold a valid entry
   bit               gen_loaded [DEPTH];
   logic [SYM_W-1:0] live_syms[$];

   task automatic add_req(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                          input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len,
                          input bit hold);
      huff_req_type r;
      r.op             = op;
      r.symbol         = sym;
      r.code_bits      = bits;
      r.code_length    = len;
      r.hold_for_drain = hold;
      pending_reqs.push_back(r);
   endtask

   // work out the bytes one accepted request produces and queue them
   task automatic pack_codes(input huff_req_type r);
      logic [63:0]       acc;
      logic [63:0]       slice;
      int                total;
      int                ln;
      packed_byte_type   pb;
      case (r.op)
         OP_LOAD: begin
            // too long a code leaves the entry as it was
            if (int'(r.code_length) <= CODE_LIMIT) begin
               ln = int'(r.code_length);
               code_valid[r.symbol] = 1'b1;
               code_len[r.symbol]   = r.code_length;
               // bits above the code length are dropped
               code_word[r.symbol]  = (ln >= CODE_W) ? r.code_bits
                                    : CODE_W'(64'(r.code_bits) & ((64'd1 << ln) - 64'd1));
            end
         end
         OP_ENCODE: begin
            // unloaded entries add nothing
            if (code_valid[r.symbol]) begin
               ln    = int'(code_len[r.symbol]);
               acc   = (64'(carry_bits) << ln) | 64'(code_word[r.symbol]);
               total = carry_cnt + ln;
               while (total >= BYTE_W) begin
                  slice          = acc >> (total - BYTE_W);
                  pb.packed_byte = slice[BYTE_W-1:0];
                  // last byte of this request once fewer than two bytes remain
                  pb.last        = (total < 2 * BYTE_W);
                  owed_bytes.push_back(pb);
                  total -= BYTE_W;
               end
               carry_bits = PEND_W'(acc & ((64'd1 << total) - 64'd1));
               carry_cnt  = total;
            end
         end
         OP_FLUSH: begin
            // partial byte goes out left aligned, zero filled below
            if (carry_cnt != 0) begin
               pb.packed_byte = BYTE_W'(int'(carry_bits) << (BYTE_W - carry_cnt));
               pb.last        = 1'b1;
               owed_bytes.push_back(pb);
               carry_bits = '0;
               carry_cnt  = 0;
            end
         end
         default: begin
            // unused op: no effect at all
         end
      endcase
   endtask

   // request driver: new request only when the bus is free or just accepted
   always @(posedge clock) begin : drive_requests
      huff_req_type nxt;
      logic         nxt_valid;
      logic         go;
      nxt_valid = req_if.valid;
      go        = 1'b0;
      if (reset) begin
         nxt_valid = 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         // random idle, except inside the calm window
         if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 13)) begin
            // a held request waits until the bus is empty and nothing is owed
            if (!pending_reqs[0].hold_for_drain || (!req_if.valid && drained)) begin
               go = 1'b1;
            end
         end
         nxt_valid = go;
      end
      if (go) begin
         nxt = pending_reqs.pop_front();
         req_if.op          <= nxt.op;
         req_if.symbol      <= nxt.symbol;
         req_if.code_bits   <= nxt.code_bits;
         req_if.code_length <= nxt.code_length;
         sent_cnt++;
      end
      req_if.valid <= nxt_valid;
      sender_idle  <= (pending_reqs.size() == 0) && !nxt_valid;
      calm         <= (sent_cnt >= 120) && (sent_cnt < 170);
   end

   // monitor: predict on accepted requests, then check accepted bytes
   always @(posedge clock) begin : watch_channels
      huff_req_type    seen;
      packed_byte_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            seen.op             = req_if.op;
            seen.symbol         = req_if.symbol;
            seen.code_bits      = req_if.code_bits;
            seen.code_length    = req_if.code_length;
            seen.hold_for_drain = 1'b0;
            case (seen.op)
               OP_LOAD:   n_load++;
               OP_ENCODE: n_encode++;
               OP_FLUSH:  n_flush++;
               default:   n_unused++;
            endcase
            pack_codes(seen);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            n_bytes++;
            if (owed_bytes.size() == 0) begin
               $error("unexpected byte: packed_byte 0x%02h last %0b",
                      rsp_if.packed_byte, rsp_if.last);
               fail_cnt++;
            end else begin
               want = owed_bytes.pop_front();
               if (rsp_if.packed_byte !== want.packed_byte) begin
                  $error("packed_byte mismatch: expected 0x%02h, actual 0x%02h",
                         want.packed_byte, rsp_if.packed_byte);
                  fail_cnt++;
               end
               if (rsp_if.last !== want.last) begin
                  $error("last mismatch: expected %0b, actual %0b", want.last, rsp_if.last);
                  fail_cnt++;
               end
            end
         end
      end
      drained      <= (owed_bytes.size() == 0);
      // output back-pressure, ready held low during reset and never dropped in the calm window
      rsp_if.ready <= !reset && (calm || $urandom_range(99) >= 13);
   end

   // hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("huffman_encoder_bit_packer verification failed");
      $finish;
   end

   initial begin : run_test
      logic [SYM_W-1:0] sym;
      logic [LEN_W-1:0] len;
      int               roll;
      int               pick;
      bit               hold;

      // every block input known from time zero
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.op          = OP_LOAD;
      req_if.symbol      = '0;
      req_if.code_bits   = '0;
      req_if.code_length = '0;
      rsp_if.ready       = 1'b0;
      drained            = 1'b1;
      sender_idle        = 1'b0;
      calm               = 1'b0;
      fail_cnt = 0;
      sent_cnt = 0;
      n_load = 0; n_encode = 0; n_flush = 0; n_unused = 0; n_bytes = 0;
      carry_bits = '0;
      carry_cnt  = 0;
      for (int i = 0; i < DEPTH; i++) begin
         code_valid[i] = 1'b0;
         code_len[i]   = '0;
         code_word[i]  = '0;
         gen_loaded[i] = 1'b0;
      end

      // directed part: empty table, corner loads and byte boundary crossings
      add_req(OP_ENCODE, 8'h00, 32'h0, 6'd0, 1'b0);             // table still empty
      add_req(OP_FLUSH,  8'h00, 32'h0, 6'd0, 1'b0);             // nothing pending
      add_req(OP_UNUSED, 8'hff, 32'hffff_ffff, 6'd63, 1'b0);    // ignored op
      add_req(OP_LOAD,   8'h00, 32'hffff_ffff, 6'd0, 1'b0);     // empty code, valid entry
      add_req(OP_LOAD,   8'hff, 32'ha5c3_0f81, 6'd32, 1'b0);    // longest code
      add_req(OP_LOAD,   8'h01, 32'hffff_fff5, 6'd3, 1'b0);     // upper bits dropped
      add_req(OP_LOAD,   8'h02, 32'h1234_5678, 6'd33, 1'b0);    // one bit too long
      add_req(OP_LOAD,   8'h03, 32'h0, 6'd63, 1'b0);            // far too long
      add_req(OP_LOAD,   8'h04, 32'h0000_0001, 6'd1, 1'b0);
      add_req(OP_LOAD,   8'h05, 32'h7fff_ff2a, 6'd7, 1'b0);
      add_req(OP_ENCODE, 8'h02, 32'h0, 6'd0, 1'b0);          // rejected load left it invalid
      add_req(OP_ENCODE, 8'h00, 32'h0, 6'd0, 1'b0);             // empty code adds nothing
      add_req(OP_ENCODE, 8'h01, 32'h0, 6'd0, 1'b0);
      add_req(OP_ENCODE, 8'h05, 32'h0, 6'd0, 1'b0);             // crosses one byte
      add_req(OP_ENCODE, 8'hff, 32'h0, 6'd0, 1'b0);             // four bytes at once
      add_req(OP_FLUSH,  8'h00, 32'h0, 6'd0, 1'b0);
      add_req(OP_ENCODE, 8'h04, 32'h0, 6'd0, 1'b0);
      add_req(OP_ENCODE, 8'hff, 32'h0, 6'd0, 1'b0);
      add_req(OP_ENCODE, 8'h05, 32'h0, 6'd0, 1'b0);             // lands exactly on a byte
      add_req(OP_FLUSH,  8'h00, 32'h0, 6'd0, 1'b0);             // nothing left
      add_req(OP_LOAD,   8'h01, 32'h0, 6'd40, 1'b0);            // too long, old code stays
      add_req(OP_ENCODE, 8'h01, 32'h0, 6'd0, 1'b0);
      add_req(OP_LOAD,   8'h80, 32'h0, 6'd8, 1'b0);
      add_req(OP_ENCODE, 8'h80, 32'h0, 6'd0, 1'b0);
      add_req(OP_FLUSH,  8'h00, 32'h0, 6'd0, 1'b0);
      foreach (pending_reqs[i]) begin
         if (pending_reqs[i].op == OP_LOAD &&
             int'(pending_reqs[i].code_length) <= CODE_LIMIT &&
             !gen_loaded[pending_reqs[i].symbol]) begin
            gen_loaded[pending_reqs[i].symbol] = 1'b1;
            live_syms.push_back(pending_reqs[i].symbol);
         end
      end

      // random part: mostly encodes of loaded symbols, some loads, flushes and unused ops
      for (int i = 0; i < 245; i++) begin
         roll = $urandom_range(99);
         hold = (i == 80) || (i == 200);
         if (roll < 14) begin
            sym  = SYM_W'($urandom_range(255));
            pick = $urandom_range(99);
            if (pick < 5)       len = 6'd0;
            else if (pick < 50) len = LEN_W'($urandom_range(8, 1));
            else if (pick < 75) len = LEN_W'($urandom_range(20, 9));
            else if (pick < 90) len = LEN_W'($urandom_range(32, 21));
            else                len = LEN_W'($urandom_range(63, 33));
            add_req(OP_LOAD, sym, $urandom(), len, hold);
            if (int'(len) <= CODE_LIMIT && !gen_loaded[sym]) begin
               gen_loaded[sym] = 1'b1;
               live_syms.push_back(sym);
            end
         end else if (roll < 82) begin
            // occasionally a symbol that may never have been loaded
            if ($urandom_range(99) < 88)
               sym = live_syms[$urandom_range(live_syms.size() - 1)];
            else
               sym = SYM_W'($urandom_range(255));
            add_req(OP_ENCODE, sym, $urandom(), LEN_W'($urandom_range(63)), hold);
         end else if (roll < 95) begin
            add_req(OP_FLUSH, SYM_W'($urandom_range(255)), $urandom(),
                    LEN_W'($urandom_range(63)), hold);
         end else begin
            add_req(OP_UNUSED, SYM_W'($urandom_range(255)), $urandom(),
                    LEN_W'($urandom_range(63)), hold);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // all requests out and every owed byte back
      do begin
         @(posedge clock);
      end while (!(sender_idle && drained));
      // room for any stray byte that arrives late
      repeat (10) @(posedge clock);

      $display("requests: %0d loads, %0d encodes, %0d flushes, %0d unused ops",
               n_load, n_encode, n_flush, n_unused);
      $display("packed bytes compared: %0d, errors: %0d", n_bytes, fail_cnt);
      if (fail_cnt == 0) begin
         $display("huffman_encoder_bit_packer verification clean");
      end else begin
         $display("huffman_encoder_bit_packer verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
